// ===== rtl/ufd_pkg.sv =====
// Shared types, codes and character helpers for the form field decoder.
`timescale 1ns / 1ps
package ufd_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [3:0] NOMATCH = 4'd15;

  // in_value_of codes
  localparam logic [2:0] IV_NAME = 3'd0;
  localparam logic [2:0] IV_SKIP = 3'd5;

  // port parser phases
  localparam logic [2:0] PH_WS = 3'd0;
  localparam logic [2:0] PH_SIGN = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_ENDED = 3'd3;
  localparam logic [2:0] PH_BAD = 3'd4;

  // status codes
  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_SSID_ABSENT = 4'd1;
  localparam logic [3:0] ST_SSID_LONG = 4'd2;
  localparam logic [3:0] ST_SSID_NUL = 4'd3;
  localparam logic [3:0] ST_PASS_LONG = 4'd4;
  localparam logic [3:0] ST_HOST_ABSENT = 4'd5;
  localparam logic [3:0] ST_HOST_LONG = 4'd6;
  localparam logic [3:0] ST_PORT_ABSENT = 4'd7;
  localparam logic [3:0] ST_PORT_BAD = 4'd8;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        item_kind;
    logic [1:0]  field_tag;
    logic [7:0]  data_byte;
    logic [6:0]  byte_index;
    logic [3:0]  status;
    logic [15:0] port_value;
    logic        end_of_run;
  } item_t;

  // all results caused by one input beat
  typedef struct packed {
    logic [2:0]      cnt;
    item_t [3:0]     items;
  } bundle_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic logic [7:0] plain_map(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

  function automatic logic [7:0] key_char(input logic [1:0] k, input logic [2:0] p);
    logic [63:0] s;
    case (k)
      2'd0: s = {8'h00, 8'h00, 8'h00, 8'h00, "d", "i", "s", "s"};
      2'd1: s = {"d", "r", "o", "w", "s", "s", "a", "p"};
      2'd2: s = {8'h00, 8'h00, 8'h00, 8'h00, "t", "s", "o", "h"};
      default: s = {8'h00, 8'h00, 8'h00, 8'h00, "t", "r", "o", "p"};
    endcase
    return s[p*8 +: 8];
  endfunction

  function automatic logic [3:0] key_len(input logic [1:0] k);
    return (k == 2'd1) ? 4'd8 : 4'd4;
  endfunction

endpackage

// ===== rtl/url_form_field_decoder.sv =====
// Top level of the url-encoded form field decoder.
//
//  channel  | dir | beat contents
//  s_axis   | in  | tdata[7:0] body_byte, tlast last_byte
//  m_axis   | out | tdata data_byte/byte_index/status/port_value,
//           |     | tuser item_kind/field_tag, tlast end_of_run
//
// The parser takes one body byte every cycle while its queue has room; each
// byte yields up to four results (at most three decoded bytes and the status
// on the last byte), packed as one bundle into a four-deep queue.
// The output stage sends one result per cycle unless the output stalls, so
// input sustains one byte per cycle if each byte yields at most one result.
// Reset clears all parse state, the queue and the output valid flag; the
// parser also returns to its reset state after every last byte.
// A stalled output fills the queue and then holds s_axis_tready low.
`timescale 1ns / 1ps
module url_form_field_decoder #(
  parameter int SSID_BYTES = 33,
  parameter int PASS_BYTES = 65,
  parameter int HOST_BYTES = 64,
  parameter int PORT_MAX_CHARS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] body_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] data_byte, [14:8] byte_index,
                                      // [18:15] status, [34:19] port_value
  output logic [2:0]  m_axis_tuser,   // [0] item_kind, [2:1] field_tag
  output logic        m_axis_tlast
);

  ufd_pkg::bundle_t wr_bundle, head;
  logic push, pop, full, empty, take;

  // accept whenever the queue can hold a further bundle
  assign s_axis_tready = !full;
  assign take = s_axis_tvalid && s_axis_tready;

  ufd_front #(
    .SSID_BYTES(SSID_BYTES),
    .PASS_BYTES(PASS_BYTES),
    .HOST_BYTES(HOST_BYTES),
    .PORT_MAX_CHARS(PORT_MAX_CHARS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .take(take),
    .body_byte(s_axis_tdata),
    .last_byte(s_axis_tlast),
    .bundle(wr_bundle),
    .push(push)
  );

  ufd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_data(wr_bundle),
    .pop(pop),
    .head(head),
    .full(full),
    .empty(empty)
  );

  ufd_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .empty(empty),
    .pop(pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

endmodule

// ===== rtl/ufd_front.sv =====
// Front end: parses each body byte and builds the bundle of results it causes.
`timescale 1ns / 1ps
module ufd_front #(
  parameter int SSID_BYTES = 33,
  parameter int PASS_BYTES = 65,
  parameter int HOST_BYTES = 64,
  parameter int PORT_MAX_CHARS = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       body_byte,
  input  logic             last_byte,
  output ufd_pkg::bundle_t bundle,
  output logic             push
);

  logic [1:0]  held, held_next;
  logic [7:0]  h1, h1_next;
  logic [3:0]  pos [4];
  logic [3:0]  pos_next [4];
  logic [2:0]  inval, inval_next;
  logic [3:0]  claimed, claimed_next;
  logic [3:0]  nonempty, nonempty_next;
  logic [6:0]  dlen [3];
  logic [6:0]  dlen_next [3];
  logic [2:0]  ovf, ovf_next;
  logic        fdz, fdz_next;
  logic [2:0]  prc, prc_next;
  logic [16:0] acc, acc_next;
  logic [2:0]  phase, phase_next;

  always_comb begin
    logic        fld_end;
    logic        found;
    logic [1:0]  ek;
    logic        ek_ok;
    logic [7:0]  cand [3];
    logic [1:0]  ncand;
    logic [6:0]  len;
    logic [7:0]  cap;
    logic [2:0]  ni;
    logic [4:0]  hx_a;
    logic [4:0]  hx_b;
    logic [19:0] prod;
    logic [3:0]  st;
    held_next = held;
    h1_next = h1;
    pos_next = pos;
    inval_next = inval;
    claimed_next = claimed;
    nonempty_next = nonempty;
    dlen_next = dlen;
    ovf_next = ovf;
    fdz_next = fdz;
    prc_next = prc;
    acc_next = acc;
    phase_next = phase;
    fld_end = 1'b0;
    found = 1'b0;
    cand[0] = 8'd0;
    cand[1] = 8'd0;
    cand[2] = 8'd0;
    ncand = 2'd0;
    ni = 3'd0;
    bundle = '0;
    prod = 20'd0;
    st = ufd_pkg::ST_OK;
    hx_a = ufd_pkg::hex_val(h1);
    hx_b = ufd_pkg::hex_val(body_byte);
    ek = inval[1:0] - 2'd1;
    ek_ok = (inval >= 3'd1) && (inval <= 3'd3);

    if (inval == ufd_pkg::IV_NAME) begin
      if (body_byte == ufd_pkg::CH_AMP) begin
        fld_end = 1'b1;
      end else if (body_byte == ufd_pkg::CH_EQ) begin
        inval_next = ufd_pkg::IV_SKIP;
        for (int k = 0; k < 4; k++) begin
          if (!found && pos[k] == ufd_pkg::key_len(2'(k))) begin
            found = 1'b1;
            if (!claimed[k]) begin
              claimed_next[k] = 1'b1;
              inval_next = 3'(k + 1);
            end
          end
        end
      end else begin
        for (int k = 0; k < 4; k++) begin
          if (pos[k] < ufd_pkg::key_len(2'(k)) &&
              ufd_pkg::key_char(2'(k), pos[k][2:0]) == body_byte)
            pos_next[k] = pos[k] + 4'd1;
          else
            pos_next[k] = ufd_pkg::NOMATCH;
        end
      end
    end else if (body_byte == ufd_pkg::CH_AMP) begin
      fld_end = 1'b1;
    end else if (inval == 3'd4) begin
      // port value: strtol-style scan
      nonempty_next[3] = 1'b1;
      if (prc < 3'd7) prc_next = prc + 3'd1;
      if (phase < ufd_pkg::PH_ENDED) begin
        if (body_byte >= 8'h30 && body_byte <= 8'h39) begin
          prod = {3'd0, acc} * 20'd10 + {16'd0, body_byte[3:0]};
          acc_next = (prod > 20'd65536) ? 17'd65536 : prod[16:0];
          phase_next = ufd_pkg::PH_DIGITS;
        end else if (phase == ufd_pkg::PH_DIGITS && body_byte == 8'd0) begin
          phase_next = ufd_pkg::PH_ENDED;
        end else if (phase == ufd_pkg::PH_WS &&
                     ((body_byte >= 8'd9 && body_byte <= 8'd13) ||
                      body_byte == ufd_pkg::CH_SPACE)) begin
          phase_next = ufd_pkg::PH_WS;
        end else if (phase == ufd_pkg::PH_WS && body_byte == ufd_pkg::CH_PLUS) begin
          phase_next = ufd_pkg::PH_SIGN;
        end else begin
          phase_next = ufd_pkg::PH_BAD;
        end
      end
    end else if (ek_ok) begin
      nonempty_next[ek] = 1'b1;
      if (held == 2'd0) begin
        if (body_byte == ufd_pkg::CH_PCT) begin
          held_next = 2'd1;
        end else begin
          cand[ncand] = ufd_pkg::plain_map(body_byte);
          ncand = ncand + 2'd1;
        end
      end else if (held == 2'd1) begin
        held_next = 2'd2;
        h1_next = body_byte;
      end else begin
        held_next = 2'd0;
        if (hx_a[4] && hx_b[4]) begin
          cand[ncand] = {hx_a[3:0], hx_b[3:0]};
          ncand = ncand + 2'd1;
        end else begin
          // invalid escape: literal '%', rescan both bytes
          cand[ncand] = ufd_pkg::CH_PCT;
          ncand = ncand + 2'd1;
          if (h1 == ufd_pkg::CH_PCT) begin
            held_next = 2'd1;
          end else begin
            cand[ncand] = ufd_pkg::plain_map(h1);
            ncand = ncand + 2'd1;
          end
          if (held_next == 2'd1) begin
            held_next = 2'd2;
            h1_next = body_byte;
          end else if (body_byte == ufd_pkg::CH_PCT) begin
            held_next = 2'd1;
          end else begin
            cand[ncand] = ufd_pkg::plain_map(body_byte);
            ncand = ncand + 2'd1;
          end
        end
      end
    end

    if (fld_end || last_byte) begin
      // flush a cut-short escape as plain bytes
      if (ek_ok && held_next != 2'd0) begin
        cand[ncand] = ufd_pkg::CH_PCT;
        ncand = ncand + 2'd1;
        if (held_next == 2'd2) begin
          cand[ncand] = ufd_pkg::plain_map(h1_next);
          ncand = ncand + 2'd1;
        end
      end
      held_next = 2'd0;
      inval_next = ufd_pkg::IV_NAME;
      for (int k = 0; k < 4; k++) pos_next[k] = 4'd0;
    end

    case (ek)
      2'd0: cap = 8'(SSID_BYTES);
      2'd1: cap = 8'(PASS_BYTES);
      default: cap = 8'(HOST_BYTES);
    endcase
    len = (ek_ok) ? dlen[ek] : 7'd0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < ncand && ek_ok) begin
        if ({1'b0, len} + 8'd1 >= cap) begin
          ovf_next[ek] = 1'b1;
        end else begin
          if (ek == 2'd0 && len == 7'd0 && cand[i] == 8'd0) fdz_next = 1'b1;
          bundle.items[ni[1:0]].item_kind = ufd_pkg::KIND_DATA;
          bundle.items[ni[1:0]].field_tag = ek;
          bundle.items[ni[1:0]].data_byte = cand[i];
          bundle.items[ni[1:0]].byte_index = len;
          ni = ni + 3'd1;
          len = len + 7'd1;
        end
      end
    end
    if (ek_ok) dlen_next[ek] = len;

    if (last_byte) begin
      if (!claimed_next[0] || !nonempty_next[0]) st = ufd_pkg::ST_SSID_ABSENT;
      else if (ovf_next[0]) st = ufd_pkg::ST_SSID_LONG;
      else if (fdz_next) st = ufd_pkg::ST_SSID_NUL;
      else if (ovf_next[1]) st = ufd_pkg::ST_PASS_LONG;
      else if (!claimed_next[2] || !nonempty_next[2]) st = ufd_pkg::ST_HOST_ABSENT;
      else if (ovf_next[2]) st = ufd_pkg::ST_HOST_LONG;
      else if (!claimed_next[3] || !nonempty_next[3] || prc_next > 3'(PORT_MAX_CHARS))
        st = ufd_pkg::ST_PORT_ABSENT;
      else if ((phase_next != ufd_pkg::PH_DIGITS && phase_next != ufd_pkg::PH_ENDED) ||
               acc_next < 17'd1 || acc_next > 17'd65535)
        st = ufd_pkg::ST_PORT_BAD;
      bundle.items[ni[1:0]].item_kind = ufd_pkg::KIND_STATUS;
      bundle.items[ni[1:0]].status = st;
      bundle.items[ni[1:0]].port_value = (st == ufd_pkg::ST_OK) ? acc_next[15:0] : 16'd0;
      bundle.items[ni[1:0]].end_of_run = 1'b1;
      ni = ni + 3'd1;
      // start afresh for the next body
      held_next = 2'd0;
      h1_next = 8'd0;
      inval_next = ufd_pkg::IV_NAME;
      claimed_next = 4'd0;
      nonempty_next = 4'd0;
      for (int k = 0; k < 3; k++) dlen_next[k] = 7'd0;
      ovf_next = 3'd0;
      fdz_next = 1'b0;
      prc_next = 3'd0;
      acc_next = 17'd0;
      phase_next = ufd_pkg::PH_WS;
    end
    bundle.cnt = ni;
  end

  assign push = take && (bundle.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 2'd0;
      h1 <= 8'd0;
      for (int k = 0; k < 4; k++) pos[k] <= 4'd0;
      inval <= ufd_pkg::IV_NAME;
      claimed <= 4'd0;
      nonempty <= 4'd0;
      for (int k = 0; k < 3; k++) dlen[k] <= 7'd0;
      ovf <= 3'd0;
      fdz <= 1'b0;
      prc <= 3'd0;
      acc <= 17'd0;
      phase <= ufd_pkg::PH_WS;
    end else if (take) begin
      held <= held_next;
      h1 <= h1_next;
      pos <= pos_next;
      inval <= inval_next;
      claimed <= claimed_next;
      nonempty <= nonempty_next;
      dlen <= dlen_next;
      ovf <= ovf_next;
      fdz <= fdz_next;
      prc <= prc_next;
      acc <= acc_next;
      phase <= phase_next;
    end
  end

endmodule

// ===== rtl/ufd_queue.sv =====
// Short bundle queue between the parser and the output stage.
`timescale 1ns / 1ps
module ufd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ufd_pkg::bundle_t wr_data,
  input  logic             pop,
  output ufd_pkg::bundle_t head,
  output logic             full,
  output logic             empty
);

  ufd_pkg::bundle_t mem [ufd_pkg::QDEPTH];
  logic [ufd_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [ufd_pkg::QPTR_W:0]   count;

  assign full = (count == (ufd_pkg::QPTR_W + 1)'(ufd_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ufd_back.sv =====
// Back end: unpacks queued bundles into single result beats via an output register.
`timescale 1ns / 1ps
module ufd_back (
  input  logic             clk,
  input  logic             rst,
  input  ufd_pkg::bundle_t head,
  input  logic             empty,
  output logic             pop,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  logic [1:0]    sel;
  logic          load;
  logic          last_of_bundle;
  ufd_pkg::item_t out_item;

  assign load = !empty && (!m_axis_tvalid || m_axis_tready);
  assign last_of_bundle = ({1'b0, sel} + 3'd1 == head.cnt);
  assign pop = load && last_of_bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 2'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_axis_tvalid <= 1'b1;
        sel <= last_of_bundle ? 2'd0 : sel + 2'd1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_item <= head.items[sel];
  end

  assign m_axis_tdata = {5'd0, out_item.port_value, out_item.status,
                         out_item.byte_index, out_item.data_byte};
  assign m_axis_tuser = {out_item.field_tag, out_item.item_kind};
  assign m_axis_tlast = out_item.end_of_run;

endmodule
